// ----- rtl/rgqh_pkg.sv -----
`timescale 1ns / 1ps
// Package for the RGB565 gray quantizer with frame histogram.
// Holds payload types, controller/datapath command types, constants and helpers.
// No dependencies.
package rgqh_pkg;

  localparam int NumBins   = 8;
  localparam int CountW    = 21;
  localparam int SumW      = 23;
  localparam int LevelW    = 3;
  localparam int CoefW     = 16;
  localparam int ChanW     = 8;
  localparam int ProdW     = ChanW + CoefW;
  localparam int LumaW     = ProdW + 2;
  localparam int LumaShift = 21;
  localparam int DivW      = SumW + 1;

  localparam int MaxPixels = 1048576;
  localparam int CountMax  = 2097151;
  localparam logic [CountW-1:0] PixelCap =
    CountW'((MaxPixels > CountMax) ? CountMax : MaxPixels);

  localparam int Max5 = 31;
  localparam int Max6 = 63;

  // Register indexes of the configuration port.
  localparam logic [1:0] CfgCoefRed   = 2'd0;
  localparam logic [1:0] CfgCoefGreen = 2'd1;
  localparam logic [1:0] CfgCoefBlue  = 2'd2;

  localparam logic [CoefW-1:0] CoefRedRst   = 16'd13933;
  localparam logic [CoefW-1:0] CoefGreenRst = 16'd46871;
  localparam logic [CoefW-1:0] CoefBlueRst  = 16'd4732;

  // Record kinds of a result.
  localparam logic [1:0] KindPixel   = 2'd0;
  localparam logic [1:0] KindBin     = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        end_of_frame;
  } pixel_in_t;

  typedef struct packed {
    logic [1:0]        record_kind;
    logic [LevelW-1:0] level_idx;
    logic [CountW-1:0] count;
    logic [LevelW-1:0] average_level;
    logic              last;
  } result_t;

  typedef struct packed {
    logic        load_in;
    logic        load_prod;
    logic        load_lvl;
    logic        emit;
    logic [1:0]  emit_kind;
    logic        emit_last;
    logic        div_start;
    logic        div_step;
    logic [1:0]  step_idx;
    logic [2:0]  bin_idx;
    logic        clear_stats;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic eof;
  } ctrl_sts_t;

  // floor(x*255/31) = 8x + floor(7x/31); the fraction is found by compares.
  function automatic logic [ChanW-1:0] expand5(input logic [4:0] x);
    logic [7:0] x7;
    logic [2:0] q;
    x7 = {x, 3'b000} - {3'b000, x};
    q  = '0;
    for (int t = 1; t < 8; t++) begin
      if (x7 >= 8'(Max5 * t)) q = 3'(t);
    end
    return {x, 3'b000} + {5'b00000, q};
  endfunction

  // floor(x*255/63) = 4x + floor(x/21).
  function automatic logic [ChanW-1:0] expand6(input logic [5:0] x);
    logic [1:0] q;
    q = '0;
    for (int t = 1; t < 4; t++) begin
      if (x >= 6'(Max6 * t / 3)) q = 2'(t);
    end
    return {x, 2'b00} + {6'b000000, q};
  endfunction

endpackage

// ----- rtl/rgqh_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the gray quantizer: one-hot state machine issuing datapath commands.
// Depends on rgqh_pkg.
module rgqh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rgqh_pkg::ctrl_sts_t   sts_i,
  output rgqh_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMul  = 7'b0000010,
    StLvl  = 7'b0000100,
    StEmit = 7'b0001000,
    StDiv  = 7'b0010000,
    StBins = 7'b0100000,
    StSumm = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.step_idx = cnt_q[1:0];
    cmd_o.bin_idx  = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.load_prod = 1'b1;
        state_d = StLvl;
      end
      StLvl: begin
        cmd_o.load_lvl = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = rgqh_pkg::KindPixel;
          cmd_o.emit_last = !sts_i.eof;
          if (sts_i.eof) begin
            cmd_o.div_start = 1'b1;
            cnt_d   = '0;
            state_d = StDiv;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q[1:0] == 2'b11) begin
          cnt_d   = '0;
          state_d = StBins;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      StBins: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = rgqh_pkg::KindBin;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'(rgqh_pkg::NumBins - 1)) state_d = StSumm;
        end
      end
      StSumm: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = rgqh_pkg::KindSummary;
          cmd_o.emit_last   = 1'b1;
          cmd_o.clear_stats = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/rgqh_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the gray quantizer: expansion, luma products, statistics,
// average divider, coefficient registers and output register. Depends on rgqh_pkg.
module rgqh_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgqh_pkg::pixel_in_t   in_data_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  rgqh_pkg::ctrl_cmd_t   cmd_i,
  output rgqh_pkg::ctrl_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rgqh_pkg::result_t     out_data_o
);

  logic [rgqh_pkg::CoefW-1:0]  coef_r_q, coef_g_q, coef_b_q;
  logic [rgqh_pkg::ChanW-1:0]  chan_r_q, chan_g_q, chan_b_q;
  logic                        eof_q;
  logic [rgqh_pkg::ProdW-1:0]  prod_r_q, prod_g_q, prod_b_q;
  logic [rgqh_pkg::LevelW-1:0] lvl_q;
  logic [rgqh_pkg::CountW-1:0] bins_q [rgqh_pkg::NumBins];
  logic [rgqh_pkg::SumW-1:0]   sum_q;
  logic [rgqh_pkg::CountW-1:0] pixels_q;
  logic [rgqh_pkg::DivW-1:0]   rem_q;
  logic [2:0]                  quo_q;
  logic                        sat_q;
  logic                        out_valid_q;
  rgqh_pkg::result_t           out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_r_q <= rgqh_pkg::CoefRedRst;
      coef_g_q <= rgqh_pkg::CoefGreenRst;
      coef_b_q <= rgqh_pkg::CoefBlueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rgqh_pkg::CfgCoefRed:   coef_r_q <= cfg_data_i;
        rgqh_pkg::CfgCoefGreen: coef_g_q <= cfg_data_i;
        rgqh_pkg::CfgCoefBlue:  coef_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Channel expansion and luma products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      chan_r_q <= rgqh_pkg::expand5(in_data_i.pixel_rgb565[15:11]);
      chan_g_q <= rgqh_pkg::expand6(in_data_i.pixel_rgb565[10:5]);
      chan_b_q <= rgqh_pkg::expand5(in_data_i.pixel_rgb565[4:0]);
      eof_q    <= in_data_i.end_of_frame;
    end
    if (cmd_i.load_prod) begin
      prod_r_q <= rgqh_pkg::ProdW'(chan_r_q) * rgqh_pkg::ProdW'(coef_r_q);
      prod_g_q <= rgqh_pkg::ProdW'(chan_g_q) * rgqh_pkg::ProdW'(coef_g_q);
      prod_b_q <= rgqh_pkg::ProdW'(chan_b_q) * rgqh_pkg::ProdW'(coef_b_q);
    end
  end

  logic [rgqh_pkg::LumaW-1:0]  luma;
  logic [4:0]                  lvl_raw;
  logic [rgqh_pkg::LevelW-1:0] lvl_new;
  logic                        take;
  logic [rgqh_pkg::DivW-1:0]   sum_ext;

  assign luma    = {2'b00, prod_r_q} + {2'b00, prod_g_q} + {2'b00, prod_b_q};
  assign lvl_raw = luma[rgqh_pkg::LumaW-1:rgqh_pkg::LumaShift];
  assign lvl_new = (|lvl_raw[4:3]) ? '1 : lvl_raw[2:0];
  assign take    = pixels_q < rgqh_pkg::PixelCap;
  assign sum_ext = {1'b0, sum_q} + rgqh_pkg::DivW'(lvl_new);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_lvl) lvl_q <= lvl_new;
  end

  // Frame statistics; each bin counts only its own level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rgqh_pkg::NumBins; i++) bins_q[i] <= '0;
      sum_q    <= '0;
      pixels_q <= '0;
    end else if (cmd_i.clear_stats) begin
      for (int i = 0; i < rgqh_pkg::NumBins; i++) bins_q[i] <= '0;
      sum_q    <= '0;
      pixels_q <= '0;
    end else if (cmd_i.load_lvl && take) begin
      for (int i = 0; i < rgqh_pkg::NumBins; i++) begin
        if (lvl_new == 3'(i) && bins_q[i] != '1) begin
          bins_q[i] <= bins_q[i] + rgqh_pkg::CountW'(1);
        end
      end
      sum_q    <= sum_ext[rgqh_pkg::DivW-1] ? '1 : sum_ext[rgqh_pkg::SumW-1:0];
      pixels_q <= pixels_q + rgqh_pkg::CountW'(1);
    end
  end

  // Average divider: a saturation test against 8 times the count, then
  // one restoring step per quotient bit.
  logic [1:0]                shamt;
  logic [rgqh_pkg::DivW-1:0] dvs;
  logic                      ge;

  assign shamt = 2'd3 - cmd_i.step_idx;
  assign dvs   = {3'b000, pixels_q} << shamt;
  assign ge    = rem_q >= dvs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= {1'b0, sum_q};
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.div_step && ge) begin
      if (cmd_i.step_idx == 2'd0) begin
        sat_q <= 1'b1;
      end else begin
        rem_q        <= rem_q - dvs;
        quo_q[shamt] <= 1'b1;
      end
    end
  end

  logic [rgqh_pkg::LevelW-1:0] avg;
  assign avg = (pixels_q == '0) ? '0 : (sat_q ? '1 : quo_q);

  // Output register.
  rgqh_pkg::result_t res;
  always_comb begin
    res             = '0;
    res.record_kind = cmd_i.emit_kind;
    res.last        = cmd_i.emit_last;
    case (cmd_i.emit_kind)
      rgqh_pkg::KindPixel: res.level_idx = lvl_q;
      rgqh_pkg::KindBin: begin
        res.level_idx = cmd_i.bin_idx;
        res.count     = bins_q[cmd_i.bin_idx];
      end
      rgqh_pkg::KindSummary: begin
        res.count         = pixels_q;
        res.average_level = avg;
      end
      default: ;
    endcase
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.eof      = eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/rgb565_gray_quantize_histogram.sv -----
`timescale 1ns / 1ps
// Top level of the RGB565 to 8-level gray quantizer with frame histogram.
// Depends on rgqh_pkg, rgqh_ctrl and rgqh_dp.
//
//   Channel  Direction  Handshake                      Payload
//   in       input      in_valid_i / in_stall_o        rgqh_pkg::pixel_in_t
//   out      output     out_valid_o / out_stall_i      rgqh_pkg::result_t
//   cfg      input      cfg_we_i, cfg_index_i          cfg_data_i (16 bits)
//
// From the acceptance of one pixel to the next, when the output is not
// stalled, the steps are input expansion, the three coefficient products,
// the level sum with statistics update, and the write of the output register.
// A pixel with the end-of-frame mark adds the divider steps and the result
// records (eight bins, one summary), all walked by the single sequencer
// one step per cycle unless the output stalls.
// Reset is asynchronous and active low; it restores the BT.709 weights and
// clears the statistics. An output stall holds the output register and the
// sequencer waits at its next result; a new request is taken while the last
// result of the previous one still waits in the output register.
module rgb565_gray_quantize_histogram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rgqh_pkg::pixel_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rgqh_pkg::result_t    out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  rgqh_pkg::ctrl_cmd_t cmd;
  rgqh_pkg::ctrl_sts_t sts;

  // The sequencer owns the input handshake and decides each datapath step.
  rgqh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the weights, statistics and the output register.
  rgqh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A request is processed alone, so the input closes right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a request is in progress");

  // A pixel record carries no count and no average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.record_kind == rgqh_pkg::KindPixel) |->
    (out_data_o.count == '0 && out_data_o.average_level == '0))
    else $error("pixel record with count or average");

  // The summary always closes the results of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.record_kind == rgqh_pkg::KindSummary) |->
    out_data_o.last)
    else $error("summary record without last");

  // Bin records never end a request, and the kind code stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.record_kind == rgqh_pkg::KindPixel ||
                     (out_data_o.record_kind == rgqh_pkg::KindBin && !out_data_o.last) ||
                     out_data_o.record_kind == rgqh_pkg::KindSummary))
    else $error("bad record kind or last flag");

endmodule
